### rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI transaction engine package
// Phase codes, tokens and item field widths shared by the engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] P_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] P_SEND  = 4'd1;
    localparam logic [PHASE_W-1:0] P_R1    = 4'd2;
    localparam logic [PHASE_W-1:0] P_EXTRA = 4'd3;
    localparam logic [PHASE_W-1:0] P_TOKEN = 4'd4;
    localparam logic [PHASE_W-1:0] P_RDATA = 4'd5;
    localparam logic [PHASE_W-1:0] P_RCRC  = 4'd6;
    localparam logic [PHASE_W-1:0] P_WDATA = 4'd7;
    localparam logic [PHASE_W-1:0] P_WCRC  = 4'd8;
    localparam logic [PHASE_W-1:0] P_DRESP = 4'd9;
    localparam logic [PHASE_W-1:0] P_BUSY  = 4'd10;
    localparam logic [PHASE_W-1:0] P_STOP  = 4'd11;
    localparam logic [PHASE_W-1:0] P_FINAL = 4'd12;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_R1       = 3'd1;
    localparam logic [2:0] ERR_TIMEOUT  = 3'd2;
    localparam logic [2:0] ERR_TOKEN    = 3'd3;
    localparam logic [2:0] ERR_REJECTED = 3'd4;

    localparam logic [2:0] CFG_CRC_EN    = 3'd0;
    localparam logic [2:0] CFG_RESP_LIM  = 3'd1;
    localparam logic [2:0] CFG_TOKEN_LIM = 3'd2;
    localparam logic [2:0] CFG_DRESP_LIM = 3'd3;
    localparam logic [2:0] CFG_IDLE_NEED = 3'd4;

    localparam logic [5:0] CMD_SEND_IF   = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
    localparam logic [5:0] CMD_SEND_CID  = 6'd10;
    localparam logic [5:0] CMD_STOP      = 6'd12;
    localparam logic [5:0] CMD_STATUS    = 6'd13;
    localparam logic [5:0] CMD_READ_ONE  = 6'd17;
    localparam logic [5:0] CMD_WRITE_ONE = 6'd24;
    localparam logic [5:0] CMD_WRITE_MUL = 6'd25;
    localparam logic [5:0] CMD_READ_OCR  = 6'd58;

    localparam logic [7:0] TOK_START  = 8'hFE;
    localparam logic [7:0] TOK_MULTI  = 8'hFC;
    localparam logic [7:0] TOK_STOP   = 8'hFD;
    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] DRESP_OK   = 8'h05;

    // Input beat: mode, cmd_index, argument, block_count, rx_byte, tx_data.
    localparam int IN_W  = 1 + 6 + 32 + 16 + 8 + 8;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    // Output beat: tx_byte, select_active, want_data, read_byte, read_valid,
    // r1_response, done_res, error_code, engine_busy.
    localparam int OUT_W  = 8 + 1 + 1 + 8 + 1 + 8 + 1 + 3 + 1;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // CRC7 (x^7 + x^3 + 1) over a 40-bit command head, eight bits per step.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] d);
        logic [6:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[6] ^ d[i];
            c  = {c[5:0], 1'b0};
            if (fb)
            begin
                c = c ^ 7'h09;
            end
        end
        return c;
    endfunction

endpackage

### rtl/sd_spi_transaction_engine_core.sv
// ----------------------------------------------------------------------------
// SD SPI transaction engine
// Steps an SD card SPI-mode command, response and block transfer one byte
// exchange per input beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   s_axis_tdata (fields below)
//  m_axis    out        m_axis_tvalid/tready   m_axis_tdata (fields below)
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One beat is taken per cycle while s_axis_tready is high; its result is
// registered in the output register, or in the skid stage while the output
// stalls. The whole step is one pass of the phase logic, so a new beat can
// follow in every cycle until the output register and the skid stage both
// hold results. Reset leaves the engine idle with default register values;
// the CRC7 of a start beat is built in one pass of five byte steps.
// ----------------------------------------------------------------------------
module sd_spi_transaction_engine_core
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // mode, cmd_index[6], argument[32], block_count[16], rx_byte[8], tx_data[8]
    input  logic [IN_TW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tx_byte[8], select_active, want_data, read_byte[8], read_valid,
    // r1_response[8], done_res, error_code[3], engine_busy
    output logic [OUT_TW-1:0] m_axis_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [9:0]        cfg_data
);

    // The byte counter must also reach 16 for short register reads.
    localparam int BC_W = $clog2(BLOCK_BYTES + 1) > 5 ? $clog2(BLOCK_BYTES + 1) : 5;
    localparam logic [BC_W-1:0] BLK_LAST = BC_W'(BLOCK_BYTES);

    logic       crc_en_reg;
    logic [7:0] resp_lim_reg;
    logic [9:0] token_lim_reg;
    logic [9:0] dresp_lim_reg;
    logic [7:0] idle_need_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [47:0]        shift_reg, shift_next;
    logic [BC_W-1:0]    bcnt_reg, bcnt_next;
    logic [9:0]         wcnt_reg, wcnt_next;
    logic [15:0]        blocks_reg, blocks_next;
    logic [7:0]         idle_reg, idle_next;
    logic [5:0]         cmd_reg, cmd_next;
    logic [7:0]         r1_reg, r1_next;
    logic               rej_reg, rej_next;
    logic [7:0]         last_tx_reg;

    logic [OUT_W-1:0] out_reg, skid_reg, res;
    logic             out_vld_reg, skid_vld_reg;

    logic        mode;
    logic [5:0]  in_cmd;
    logic [31:0] in_arg;
    logic [15:0] in_cnt;
    logic [7:0]  rx, txd;

    logic [7:0] tx;
    logic [7:0] rb;
    logic       rv, want, done;
    logic [2:0] err;
    logic [6:0] crc;
    logic [39:0] head;
    logic [7:0]  idle_inc;
    logic        busy_end;
    logic        accept;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !skid_vld_reg;
    assign cfg_ready = 1'b1;

    assign mode   = s_axis_tdata[0];
    assign in_cmd = s_axis_tdata[6:1];
    assign in_arg = s_axis_tdata[38:7];
    assign in_cnt = s_axis_tdata[54:39];
    assign rx     = s_axis_tdata[62:55];
    assign txd    = s_axis_tdata[70:63];

    always_comb
    begin
        head = {2'b01, in_cmd, in_arg};
        crc  = 7'd0;
        for (int k = 4; k >= 0; k--)
        begin
            crc = crc7_byte(crc, head[k*8 +: 8]);
        end
        idle_inc = (rx == BYTE_IDLE && idle_reg != 8'hFF) ? idle_reg + 8'd1 : idle_reg;
        busy_end = idle_inc >= idle_need_reg;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        bcnt_next   = bcnt_reg;
        wcnt_next   = wcnt_reg;
        blocks_next = blocks_reg;
        idle_next   = idle_reg;
        cmd_next    = cmd_reg;
        r1_next     = r1_reg;
        rej_next    = rej_reg;
        tx   = BYTE_IDLE;
        rb   = 8'd0;
        rv   = 1'b0;
        want = 1'b0;
        done = 1'b0;
        err  = ERR_OK;
        if (!mode)
        begin
            if (phase_reg != P_IDLE)
            begin
                tx   = last_tx_reg;
                want = phase_reg == P_WDATA;
            end
            else
            begin
                shift_next  = {head, crc_en_reg ? {crc, 1'b1} : BYTE_IDLE};
                cmd_next    = in_cmd;
                blocks_next = in_cnt;
                r1_next     = BYTE_IDLE;
                rej_next    = 1'b0;
                bcnt_next   = BC_W'(1);
                phase_next  = P_SEND;
                tx          = head[39:32];
            end
        end
        else
        begin
            case (phase_reg)
                P_SEND:
                begin
                    if (bcnt_reg < BC_W'(6))
                    begin
                        tx         = shift_reg[39:32];
                        shift_next = {shift_reg[39:0], 8'd0};
                        bcnt_next  = bcnt_reg + BC_W'(1);
                    end
                    else if (cmd_reg == CMD_STOP && bcnt_reg == BC_W'(6))
                    begin
                        bcnt_next = BC_W'(7);
                    end
                    else
                    begin
                        phase_next = P_R1;
                        wcnt_next  = 10'd0;
                    end
                end
                P_R1:
                begin
                    wcnt_next = wcnt_reg + 10'd1;
                    if (rx != BYTE_IDLE)
                    begin
                        r1_next = rx;
                        if (cmd_reg == CMD_SEND_IF || cmd_reg == CMD_READ_OCR
                            || cmd_reg == CMD_STATUS)
                        begin
                            phase_next = P_EXTRA;
                            bcnt_next  = '0;
                        end
                        else if ((cmd_reg == CMD_SEND_CSD || cmd_reg == CMD_SEND_CID
                                  || cmd_reg == CMD_READ_ONE) && rx == 8'd0)
                        begin
                            phase_next = P_TOKEN;
                            wcnt_next  = 10'd0;
                        end
                        else if (cmd_reg == CMD_WRITE_ONE && rx == 8'd0)
                        begin
                            tx = TOK_START; want = 1'b1;
                            phase_next = P_WDATA; bcnt_next = '0;
                        end
                        else if (cmd_reg == CMD_WRITE_MUL && rx == 8'd0)
                        begin
                            bcnt_next = '0;
                            if (blocks_reg == 16'd0)
                            begin
                                tx = TOK_STOP; phase_next = P_STOP;
                            end
                            else
                            begin
                                tx = TOK_MULTI; want = 1'b1; phase_next = P_WDATA;
                            end
                        end
                        else
                        begin
                            done = 1'b1;
                            err  = (rx == 8'd0) ? ERR_OK : ERR_R1;
                        end
                    end
                    else if (wcnt_next >= {2'b00, resp_lim_reg})
                    begin
                        done = 1'b1; err = ERR_TIMEOUT;
                    end
                end
                P_EXTRA:
                begin
                    rb = rx; rv = 1'b1;
                    bcnt_next = bcnt_reg + BC_W'(1);
                    if (bcnt_next >= ((cmd_reg == CMD_STATUS) ? BC_W'(1) : BC_W'(4)))
                    begin
                        done = 1'b1;
                        err  = (r1_reg != 8'd0) ? ERR_R1 : ERR_OK;
                    end
                end
                P_TOKEN:
                begin
                    wcnt_next = wcnt_reg + 10'd1;
                    if (rx == TOK_START)
                    begin
                        phase_next = P_RDATA; bcnt_next = '0;
                    end
                    else if (rx[7:4] == 4'd0 || wcnt_next >= token_lim_reg)
                    begin
                        done = 1'b1; err = ERR_TOKEN;
                    end
                end
                P_RDATA:
                begin
                    rb = rx; rv = 1'b1;
                    bcnt_next = bcnt_reg + BC_W'(1);
                    if (cmd_reg == CMD_READ_ONE)
                    begin
                        if (bcnt_next >= BLK_LAST)
                        begin
                            phase_next = P_RCRC; bcnt_next = '0;
                        end
                    end
                    else if (bcnt_next >= BC_W'(16))
                    begin
                        done = 1'b1;
                    end
                end
                P_RCRC:
                begin
                    bcnt_next = bcnt_reg + BC_W'(1);
                    if (bcnt_next >= BC_W'(2))
                    begin
                        done = 1'b1;
                    end
                end
                P_WDATA:
                begin
                    tx = txd;
                    bcnt_next = bcnt_reg + BC_W'(1);
                    if (bcnt_next < BLK_LAST)
                    begin
                        want = 1'b1;
                    end
                    else
                    begin
                        phase_next = P_WCRC; bcnt_next = '0;
                    end
                end
                P_WCRC:
                begin
                    bcnt_next = bcnt_reg + BC_W'(1);
                    if (bcnt_next >= BC_W'(3))
                    begin
                        phase_next = P_DRESP; wcnt_next = 10'd0;
                    end
                end
                P_DRESP:
                begin
                    wcnt_next = wcnt_reg + 10'd1;
                    if (rx[4] == 1'b0 && rx[0] == 1'b1)
                    begin
                        if ({3'd0, rx[4:0]} != DRESP_OK)
                        begin
                            rej_next = 1'b1;
                        end
                        phase_next = P_BUSY; idle_next = 8'd0;
                    end
                    else if (wcnt_next >= dresp_lim_reg)
                    begin
                        rej_next = 1'b1; phase_next = P_BUSY; idle_next = 8'd0;
                    end
                end
                P_BUSY:
                begin
                    idle_next = idle_inc;
                    if (busy_end)
                    begin
                        if (cmd_reg == CMD_WRITE_MUL)
                        begin
                            if (blocks_reg != 16'd0)
                            begin
                                blocks_next = blocks_reg - 16'd1;
                            end
                            bcnt_next = '0;
                            if (!rej_reg && blocks_next != 16'd0)
                            begin
                                tx = TOK_MULTI; want = 1'b1; phase_next = P_WDATA;
                            end
                            else
                            begin
                                tx = TOK_STOP; phase_next = P_STOP;
                            end
                        end
                        else
                        begin
                            done = 1'b1;
                            err  = rej_reg ? ERR_REJECTED : ERR_OK;
                        end
                    end
                end
                P_STOP:
                begin
                    bcnt_next = bcnt_reg + BC_W'(1);
                    if (bcnt_next >= BC_W'(2))
                    begin
                        phase_next = P_FINAL; idle_next = 8'd0;
                    end
                end
                P_FINAL:
                begin
                    idle_next = idle_inc;
                    if (busy_end)
                    begin
                        done = 1'b1;
                        err  = rej_reg ? ERR_REJECTED : ERR_OK;
                    end
                end
                default:
                begin
                    phase_next = P_IDLE;
                end
            endcase
        end
        if (done)
        begin
            phase_next = P_IDLE;
        end
        res = {phase_next != P_IDLE, err, done, r1_next, rv, rb, want,
               phase_next != P_IDLE, tx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg    <= 1'b1;
            resp_lim_reg  <= 8'd8;
            token_lim_reg <= 10'd255;
            dresp_lim_reg <= 10'd767;
            idle_need_reg <= 8'd15;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CRC_EN:    crc_en_reg    <= cfg_data[0];
                CFG_RESP_LIM:  resp_lim_reg  <= cfg_data[7:0];
                CFG_TOKEN_LIM: token_lim_reg <= cfg_data;
                CFG_DRESP_LIM: dresp_lim_reg <= cfg_data;
                CFG_IDLE_NEED: idle_need_reg <= cfg_data[7:0];
                default:       crc_en_reg    <= crc_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_IDLE;
            shift_reg   <= '0;
            bcnt_reg    <= '0;
            wcnt_reg    <= '0;
            blocks_reg  <= '0;
            idle_reg    <= '0;
            cmd_reg     <= '0;
            r1_reg      <= BYTE_IDLE;
            rej_reg     <= 1'b0;
            last_tx_reg <= BYTE_IDLE;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            bcnt_reg    <= bcnt_next;
            wcnt_reg    <= wcnt_next;
            blocks_reg  <= blocks_next;
            idle_reg    <= idle_next;
            cmd_reg     <= cmd_next;
            r1_reg      <= r1_next;
            rej_reg     <= rej_next;
            last_tx_reg <= tx;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!out_vld_reg || m_axis_tready)
            begin
                out_vld_reg  <= skid_vld_reg || accept;
                skid_vld_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_axis_tready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res;
        end
        if (accept && out_vld_reg && !m_axis_tready)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_TW - OUT_W){1'b0}}, out_reg};

`ifndef ASSERT_OFF
    a_skid_only_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid stage full while output register empty");
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode && done) |=> phase_reg == P_IDLE)
        else $error("engine did not return to idle after done");
    a_err_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !done) |-> err == ERR_OK)
        else $error("error code without done");
`endif

endmodule

### dv/sd_spi_transaction_engine_core_tb.sv
// ----------------------------------------------------------------------------
// SD SPI transaction engine testbench
// Drives command starts and byte exchange slots whose card replies follow the
// predicted phase of the engine, predicts every result beat with a behavioral
// model of the sequencer, and checks the beats in order under random stalls.
// ----------------------------------------------------------------------------
module sd_spi_transaction_engine_core_tb;
    import sdspi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_BYTES = 512;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [7:0] tx;
        logic       sel;
        logic       want;
        logic [7:0] rb;
        logic       rv;
        logic [7:0] r1;
        logic       done;
        logic [2:0] err;
        logic       busy;
    } slot_result_t;

    typedef struct {
        logic        mode;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [15:0] cnt;
        logic [7:0]  rx;
        logic [7:0]  txd;
    } slot_item_t;

    typedef struct {
        logic        mode;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [15:0] cnt;
        logic [7:0]  rx;
        logic [7:0]  txd;
        logic        chk;
        logic [7:0]  tx;
        logic        done;
        logic [2:0]  err;
    } directed_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_TW-1:0] m_axis_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [9:0]        cfg_data;

    sd_spi_transaction_engine_core #(.BLOCK_BYTES(BLOCK_BYTES)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Engine shadow: registers and sequencer state.
    logic        crc_on;
    logic [7:0]  r1_limit;
    logic [9:0]  tok_limit;
    logic [9:0]  dresp_limit;
    logic [7:0]  idle_need;
    logic [3:0]  ph;
    logic [47:0] frame;
    int unsigned byte_cnt;
    int unsigned poll_cnt;
    logic [15:0] blocks;
    logic [7:0]  ff_seen;
    logic [5:0]  cur_cmd;
    logic [7:0]  r1_seen;
    logic        reject;
    logic [7:0]  prev_tx;

    slot_result_t pending_q[$];
    int           errors;
    int           cycles;
    int           tx_idle_pct;
    int           rx_idle_pct;
    logic         hold_start;
    logic         hold_done;
    int           hold_cnt;

    directed_row_t rows[25] = '{
        '{1, 0, 0, 0, 8'hFF, 0, 1, 8'hFF, 0, ERR_OK},
        '{0, 0, 0, 0, 8'hFF, 0, 1, 8'h40, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 1, 8'h95, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 1, 8'hFF, 0, ERR_OK},
        '{0, 63, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1, 8'hFF, 0, ERR_OK},
        '{1, 0, 0, 0, 8'h01, 0, 1, 8'hFF, 1, ERR_R1},
        '{0, 63, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1, 8'h7F, 0, ERR_OK},
        '{1, 63, 32'hFFFFFFFF, 16'hFFFF, 8'h00, 8'hFF, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 1, 8'hFF, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 0, 0, 0, ERR_OK},
        '{1, 0, 0, 0, 8'hFF, 0, 1, 8'hFF, 1, ERR_TIMEOUT}
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [6:0] frame_crc7(input logic [39:0] head);
        logic [6:0] c;
        logic       fb;
        c = '0;
        for (int i = 39; i >= 0; i--)
        begin
            fb = c[6] ^ head[i];
            c  = {c[5:0], 1'b0};
            if (fb)
            begin
                c = c ^ 7'h09;
            end
        end
        return c;
    endfunction

    // Counts 0xFF replies, saturating, and reports when enough have been seen.
    function automatic logic idle_reached(input logic [7:0] rx);
        if (rx == BYTE_IDLE && ff_seen < 8'd255)
        begin
            ff_seen = ff_seen + 8'd1;
        end
        return ff_seen >= idle_need;
    endfunction

    function automatic slot_result_t next_slot(input slot_item_t it);
        slot_result_t r;
        logic [39:0]  head;
        logic         ok;
        logic [5:0]   c;
        c = cur_cmd;
        r = '{tx: BYTE_IDLE, sel: 0, want: 0, rb: 0, rv: 0, r1: 0, done: 0,
              err: ERR_OK, busy: 0};
        if (!it.mode)
        begin
            if (ph != P_IDLE)
            begin
                r.tx   = prev_tx;
                r.want = (ph == P_WDATA);
            end
            else
            begin
                head     = {2'b01, it.cmd, it.arg};
                frame    = {head, crc_on ? {frame_crc7(head), 1'b1} : BYTE_IDLE};
                cur_cmd  = it.cmd;
                blocks   = it.cnt;
                r1_seen  = BYTE_IDLE;
                reject   = 1'b0;
                byte_cnt = 1;
                ph       = P_SEND;
                r.tx     = frame[47:40];
            end
        end
        else
        begin
            case (ph)
                P_SEND:
                begin
                    if (byte_cnt < 6)
                    begin
                        r.tx     = frame[47 - 8 * byte_cnt -: 8];
                        byte_cnt = byte_cnt + 1;
                    end
                    else if (c == CMD_STOP && byte_cnt == 6)
                    begin
                        byte_cnt = 7;
                    end
                    else
                    begin
                        ph       = P_R1;
                        poll_cnt = 0;
                    end
                end
                P_R1:
                begin
                    poll_cnt = poll_cnt + 1;
                    if (it.rx != BYTE_IDLE)
                    begin
                        ok      = (it.rx == 8'h00);
                        r1_seen = it.rx;
                        if (c == CMD_SEND_IF || c == CMD_READ_OCR || c == CMD_STATUS)
                        begin
                            ph       = P_EXTRA;
                            byte_cnt = 0;
                        end
                        else if ((c == CMD_SEND_CSD || c == CMD_SEND_CID
                                  || c == CMD_READ_ONE) && ok)
                        begin
                            ph       = P_TOKEN;
                            poll_cnt = 0;
                        end
                        else if (c == CMD_WRITE_ONE && ok)
                        begin
                            r.tx     = TOK_START;
                            r.want   = 1'b1;
                            ph       = P_WDATA;
                            byte_cnt = 0;
                        end
                        else if (c == CMD_WRITE_MUL && ok)
                        begin
                            byte_cnt = 0;
                            if (blocks == 0)
                            begin
                                r.tx = TOK_STOP;
                                ph   = P_STOP;
                            end
                            else
                            begin
                                r.tx   = TOK_MULTI;
                                r.want = 1'b1;
                                ph     = P_WDATA;
                            end
                        end
                        else
                        begin
                            r.done = 1'b1;
                            r.err  = ok ? ERR_OK : ERR_R1;
                        end
                    end
                    else if (poll_cnt >= r1_limit)
                    begin
                        r.done = 1'b1;
                        r.err  = ERR_TIMEOUT;
                    end
                end
                P_EXTRA:
                begin
                    r.rb     = it.rx;
                    r.rv     = 1'b1;
                    byte_cnt = byte_cnt + 1;
                    if (byte_cnt >= ((c == CMD_STATUS) ? 1 : 4))
                    begin
                        r.done = 1'b1;
                        r.err  = (r1_seen != 8'h00) ? ERR_R1 : ERR_OK;
                    end
                end
                P_TOKEN:
                begin
                    poll_cnt = poll_cnt + 1;
                    if (it.rx == TOK_START)
                    begin
                        ph       = P_RDATA;
                        byte_cnt = 0;
                    end
                    else if (it.rx[7:4] == 4'h0 || poll_cnt >= tok_limit)
                    begin
                        r.done = 1'b1;
                        r.err  = ERR_TOKEN;
                    end
                end
                P_RDATA:
                begin
                    r.rb     = it.rx;
                    r.rv     = 1'b1;
                    byte_cnt = byte_cnt + 1;
                    if (byte_cnt >= ((c == CMD_READ_ONE) ? BLOCK_BYTES : 16))
                    begin
                        if (c == CMD_READ_ONE)
                        begin
                            ph       = P_RCRC;
                            byte_cnt = 0;
                        end
                        else
                        begin
                            r.done = 1'b1;
                        end
                    end
                end
                P_RCRC:
                begin
                    byte_cnt = byte_cnt + 1;
                    if (byte_cnt >= 2)
                    begin
                        r.done = 1'b1;
                    end
                end
                P_WDATA:
                begin
                    r.tx     = it.txd;
                    byte_cnt = byte_cnt + 1;
                    if (byte_cnt < BLOCK_BYTES)
                    begin
                        r.want = 1'b1;
                    end
                    else
                    begin
                        ph       = P_WCRC;
                        byte_cnt = 0;
                    end
                end
                P_WCRC:
                begin
                    byte_cnt = byte_cnt + 1;
                    if (byte_cnt >= 3)
                    begin
                        ph       = P_DRESP;
                        poll_cnt = 0;
                    end
                end
                P_DRESP:
                begin
                    poll_cnt = poll_cnt + 1;
                    if ((it.rx & 8'h11) == 8'h01)
                    begin
                        if ((it.rx & 8'h1F) != DRESP_OK)
                        begin
                            reject = 1'b1;
                        end
                        ph      = P_BUSY;
                        ff_seen = 0;
                    end
                    else if (poll_cnt >= dresp_limit)
                    begin
                        reject  = 1'b1;
                        ph      = P_BUSY;
                        ff_seen = 0;
                    end
                end
                P_BUSY:
                begin
                    if (idle_reached(it.rx))
                    begin
                        if (c == CMD_WRITE_MUL)
                        begin
                            if (blocks > 0)
                            begin
                                blocks = blocks - 1;
                            end
                            byte_cnt = 0;
                            if (!reject && blocks > 0)
                            begin
                                r.tx   = TOK_MULTI;
                                r.want = 1'b1;
                                ph     = P_WDATA;
                            end
                            else
                            begin
                                r.tx = TOK_STOP;
                                ph   = P_STOP;
                            end
                        end
                        else
                        begin
                            r.done = 1'b1;
                            r.err  = reject ? ERR_REJECTED : ERR_OK;
                        end
                    end
                end
                P_STOP:
                begin
                    byte_cnt = byte_cnt + 1;
                    if (byte_cnt >= 2)
                    begin
                        ph      = P_FINAL;
                        ff_seen = 0;
                    end
                end
                P_FINAL:
                begin
                    if (idle_reached(it.rx))
                    begin
                        r.done = 1'b1;
                        r.err  = reject ? ERR_REJECTED : ERR_OK;
                    end
                end
                default:
                begin
                    ph = P_IDLE;
                end
            endcase
        end
        if (r.done)
        begin
            ph = P_IDLE;
        end
        prev_tx = r.tx;
        r.sel   = (ph != P_IDLE);
        r.busy  = (ph != P_IDLE);
        r.r1    = r1_seen;
        return r;
    endfunction

    // Card replies follow the predicted phase so that most slots move the
    // transaction forward; the rest are random bytes.
    function automatic slot_item_t card_slot();
        slot_item_t it;
        int         p;
        int         k;
        p  = $urandom_range(99);
        it = '{mode: 1, cmd: 6'($urandom), arg: $urandom, cnt: 16'($urandom),
               rx: 8'($urandom), txd: 8'($urandom)};
        if (ph == P_IDLE)
        begin
            if (p < 85)
            begin
                it.mode = 1'b0;
                k = $urandom_range(13);
                case (k)
                    0: it.cmd = 6'd0;
                    1: it.cmd = CMD_SEND_IF;
                    2: it.cmd = CMD_SEND_CSD;
                    3: it.cmd = CMD_SEND_CID;
                    4: it.cmd = CMD_STOP;
                    5: it.cmd = CMD_STATUS;
                    6: it.cmd = ($urandom_range(3) == 0) ? CMD_READ_ONE : CMD_STATUS;
                    7: it.cmd = ($urandom_range(3) == 0) ? CMD_WRITE_ONE : CMD_STOP;
                    8: it.cmd = ($urandom_range(3) == 0) ? CMD_WRITE_MUL : CMD_SEND_IF;
                    9: it.cmd = CMD_READ_OCR;
                    default: it.cmd = 6'($urandom);
                endcase
                if (it.cmd == CMD_WRITE_MUL)
                begin
                    it.cnt = 16'($urandom_range(2));
                end
            end
        end
        else if (p < 4)
        begin
            it.mode = 1'b0;
        end
        else
        begin
            case (ph)
                P_R1:
                    it.rx = (p < 60) ? BYTE_IDLE : (p < 85) ? 8'h00 : 8'($urandom);
                P_TOKEN:
                    it.rx = (p < 55) ? TOK_START : (p < 85) ? BYTE_IDLE : 8'($urandom);
                P_DRESP:
                    it.rx = (p < 55) ? DRESP_OK : (p < 80) ? BYTE_IDLE : 8'($urandom);
                P_BUSY, P_FINAL:
                    it.rx = (p < 60) ? BYTE_IDLE : (p < 80) ? 8'h00 : 8'($urandom);
                default:
                    it.rx = 8'($urandom);
            endcase
        end
        return it;
    endfunction

    task automatic send_slot(input slot_item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.txd, it.rx, it.cnt, it.arg, it.cmd, it.mode};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        pending_q.push_back(next_slot(it));
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Waits out the current transaction, drains the results, then rewrites
    // every register while the engine sits idle.
    task automatic reconfigure(input logic c0, input logic [7:0] c1,
                               input logic [9:0] c2, input logic [9:0] c3,
                               input logic [7:0] c4);
        logic [9:0] vals[5];
        while (ph != P_IDLE)
        begin
            send_slot(card_slot());
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (4) @(posedge clk);
        vals = '{10'(c0), 10'(c1), c2, c3, 10'(c4)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
        end
        cfg_valid   <= 1'b0;
        crc_on      = c0;
        r1_limit    = c1;
        tok_limit   = c2;
        dresp_limit = c3;
        idle_need   = c4;
    endtask

    always @(posedge clk)
    begin
        if (hold_start && !hold_done)
        begin
            hold_cnt      <= 400;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        slot_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if ({e.busy, e.err, e.done, e.r1, e.rv, e.rb, e.want, e.sel, e.tx}
                    !== m_axis_tdata[31:0])
                begin
                    $display("%0t: mismatch exp tx=%h sel=%b want=%b rb=%h rv=%b r1=%h",
                             $time, e.tx, e.sel, e.want, e.rb, e.rv, e.r1);
                    $display("    done=%b err=%0d busy=%b, actual beat %h", e.done,
                             e.err, e.busy, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        slot_result_t r;
        slot_item_t   it;
        errors        = 0;
        cycles        = 0;
        hold_cnt      = 0;
        hold_start    = 1'b0;
        hold_done     = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        crc_on        = 1'b1;
        r1_limit      = 8'd8;
        tok_limit     = 10'd255;
        dresp_limit   = 10'd767;
        idle_need     = 8'd15;
        ph            = P_IDLE;
        frame         = '0;
        byte_cnt      = 0;
        poll_cnt      = 0;
        blocks        = '0;
        ff_seen       = '0;
        cur_cmd       = '0;
        r1_seen       = BYTE_IDLE;
        reject        = 1'b0;
        prev_tx       = BYTE_IDLE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            it = '{rows[i].mode, rows[i].cmd, rows[i].arg, rows[i].cnt, rows[i].rx,
                   rows[i].txd};
            send_slot(it);
            r = pending_q[$];
            if (rows[i].chk && (r.tx !== rows[i].tx || r.done !== rows[i].done
                                || r.err !== rows[i].err))
            begin
                $display("%0t: row %0d exp tx=%h done=%b err=%0d, model tx=%h done=%b err=%0d",
                         $time, i, rows[i].tx, rows[i].done, rows[i].err, r.tx, r.done,
                         r.err);
                errors++;
            end
        end

        // Minimum limits, CRC replaced by 0xFF; sender idles lightly.
        reconfigure(1'b0, 8'd1, 10'd1, 10'd1, 8'd1);
        tx_idle_pct = 21;
        rx_idle_pct = 66;
        repeat (500) send_slot(card_slot());

        // Maximum limits; receiver idles lightly and once holds off for long.
        reconfigure(1'b1, 8'd255, 10'd1023, 10'd1023, 8'd255);
        tx_idle_pct = 66;
        rx_idle_pct = 21;
        hold_start  = 1'b1;
        repeat (500) send_slot(card_slot());

        reconfigure(1'($urandom_range(1)), 8'($urandom_range(2, 20)),
                    10'($urandom_range(2, 40)), 10'($urandom_range(2, 40)),
                    8'($urandom_range(2, 30)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (525) send_slot(card_slot());

        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sd_spi_transaction_engine_core.f
rtl/sdspi_pkg.sv
rtl/sd_spi_transaction_engine_core.sv
dv/sd_spi_transaction_engine_core_tb.sv
